@@ hw/rtl/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, constants and the 6x8 font table of the glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int PANEL_WIDTH_DEF  = 320;
  localparam int PANEL_HEIGHT_DEF = 480;

  localparam int CELL_W      = 6;
  localparam int CELL_H      = 8;
  localparam int FIRST_CODE  = 32;
  localparam int GLYPH_COUNT = 96;

  localparam int COORD_W = 9;
  localparam int COLOR_W = 16;
  localparam int GLYPH_W = CELL_W * CELL_H;
  localparam int IDX_W   = $clog2(GLYPH_COUNT);

  // configuration register indexes
  localparam logic REG_ORIENTATION   = 1'b0;
  localparam logic REG_DISPLAY_READY = 1'b1;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_NOTHING   = 2'd1,
    ST_OFF       = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2
  } scan_state_t;

  // one accepted character request, handed from cursor logic to the scanner
  typedef struct packed {
    logic                 valid;
    status_t              kind;
    logic [COORD_W-1:0]   base_x;
    logic [COORD_W-1:0]   base_y;
    logic [COLOR_W-1:0]   fg;
    logic [COLOR_W-1:0]   bg;
  } start_t;

  // one glyph per entry, column c in bits [8c+7:8c], bit 0 of a column on top
  localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    48'h00_00_00_00_00_00, 48'h00_00_00_5F_00_00, 48'h00_00_07_00_07_00,
    48'h00_14_7F_14_7F_14, 48'h00_12_2A_7F_2A_24, 48'h00_62_64_08_13_23,
    48'h00_50_22_55_49_36, 48'h00_00_00_03_05_00, 48'h00_00_41_22_1C_00,
    48'h00_00_1C_22_41_00, 48'h00_14_08_3E_08_14, 48'h00_08_08_3E_08_08,
    48'h00_00_00_30_50_00, 48'h00_08_08_08_08_08, 48'h00_00_00_60_60_00,
    48'h00_02_04_08_10_20, 48'h00_3E_45_49_51_3E, 48'h00_00_40_7F_42_00,
    48'h00_46_49_51_61_42, 48'h00_31_4B_45_41_21, 48'h00_10_7F_12_14_18,
    48'h00_39_45_45_45_27, 48'h00_30_49_49_4A_3C, 48'h00_03_05_09_71_01,
    48'h00_36_49_49_49_36, 48'h00_1E_29_49_49_06, 48'h00_00_00_36_36_00,
    48'h00_00_00_36_56_00, 48'h00_00_41_22_14_08, 48'h00_14_14_14_14_14,
    48'h00_08_14_22_41_00, 48'h00_06_09_51_01_02, 48'h00_3E_51_59_49_32,
    48'h00_7C_12_11_12_7C, 48'h00_36_49_49_49_7F, 48'h00_22_41_41_41_3E,
    48'h00_1C_22_41_41_7F, 48'h00_41_49_49_49_7F, 48'h00_01_09_09_09_7F,
    48'h00_7A_49_49_41_3E, 48'h00_7F_08_08_08_7F, 48'h00_00_41_7F_41_00,
    48'h00_01_3F_41_40_20, 48'h00_41_22_14_08_7F, 48'h00_40_40_40_40_7F,
    48'h00_7F_02_0C_02_7F, 48'h00_7F_10_08_04_7F, 48'h00_3E_41_41_41_3E,
    48'h00_06_09_09_09_7F, 48'h00_5E_21_51_41_3E, 48'h00_46_29_19_09_7F,
    48'h00_31_49_49_49_46, 48'h00_01_01_7F_01_01, 48'h00_3F_40_40_40_3F,
    48'h00_1F_20_40_20_1F, 48'h00_3F_40_38_40_3F, 48'h00_63_14_08_14_63,
    48'h00_07_08_70_08_07, 48'h00_43_45_49_51_61, 48'h00_00_41_41_7F_00,
    48'h00_20_10_08_04_02, 48'h00_00_7F_41_41_00, 48'h00_04_02_01_02_04,
    48'h00_40_40_40_40_40, 48'h00_00_04_02_01_00, 48'h00_78_54_54_54_20,
    48'h00_38_44_44_48_7F, 48'h00_20_44_44_44_38, 48'h00_7F_48_44_44_38,
    48'h00_18_54_54_54_38, 48'h00_02_01_09_7E_08, 48'h00_3E_52_52_52_0C,
    48'h00_78_04_04_08_7F, 48'h00_00_40_7D_44_00, 48'h00_00_3D_44_40_20,
    48'h00_00_44_28_10_7F, 48'h00_00_40_7F_41_00, 48'h00_78_04_18_04_7C,
    48'h00_78_04_04_08_7C, 48'h00_38_44_44_44_38, 48'h00_08_14_14_14_7C,
    48'h00_7C_18_14_14_08, 48'h00_08_04_04_08_7C, 48'h00_20_54_54_54_48,
    48'h00_20_40_44_3F_04, 48'h00_7C_20_40_40_3C, 48'h00_1C_20_40_20_1C,
    48'h00_3C_40_30_40_3C, 48'h00_44_28_10_28_44, 48'h00_3C_50_50_50_0C,
    48'h00_44_4C_54_64_44, 48'h00_00_41_36_08_00, 48'h00_00_00_7F_00_00,
    48'h00_00_08_36_41_00, 48'h00_08_10_08_08_10, 48'h00_00_00_00_00_00
  };

endpackage

@@ hw/rtl/tcgr_glyph_rom.sv @@
// ----------------------------------------------------------------------------
// tcgr_glyph_rom
// Synchronous font memory, one whole 6x8 glyph per read, data in the cycle after the read.
// ----------------------------------------------------------------------------
module tcgr_glyph_rom (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [tcgr_pkg::IDX_W-1:0]   rd_idx,
  output logic [tcgr_pkg::GLYPH_W-1:0] rd_data
);

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tcgr_pkg::GLYPH_ROM[rd_idx];
    end
  end

endmodule

@@ hw/rtl/tcgr_cursor.sv @@
// ----------------------------------------------------------------------------
// tcgr_cursor
// Configuration registers, text cursor, wrap and off-screen decision.
// ----------------------------------------------------------------------------
module tcgr_cursor #(
  parameter int PANEL_WIDTH  = tcgr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tcgr_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [1:0]                    cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    char_code,
  input  logic [tcgr_pkg::COLOR_W-1:0]  fg_color,
  input  logic [tcgr_pkg::COLOR_W-1:0]  bg_color,
  output logic [tcgr_pkg::IDX_W-1:0]    glyph_idx,
  output tcgr_pkg::start_t              start
);

  localparam int CW = tcgr_pkg::COORD_W;
  localparam logic [CW:0] SCR_W_P = (CW+1)'(PANEL_WIDTH);
  localparam logic [CW:0] SCR_H_P = (CW+1)'(PANEL_HEIGHT);

  logic [1:0]    orientation;
  logic          display_ready;
  logic [CW-1:0] cursor_x;
  logic [CW-1:0] cursor_y;

  logic [CW:0]   scr_w;
  logic [CW:0]   scr_h;
  logic          wrap;
  logic          off;
  logic [CW-1:0] cx_w;
  logic [CW-1:0] cy_w;
  logic [7:0]    code_off;

  always_comb begin
    scr_w    = orientation[0] ? SCR_H_P : SCR_W_P;
    scr_h    = orientation[0] ? SCR_W_P : SCR_H_P;
    wrap     = ({1'b0, cursor_x} + (CW+1)'(tcgr_pkg::CELL_W)) > scr_w;
    cx_w     = wrap ? '0 : cursor_x;
    cy_w     = wrap ? cursor_y + CW'(tcgr_pkg::CELL_H) : cursor_y;
    off      = ({1'b0, cy_w} + (CW+1)'(tcgr_pkg::CELL_H)) > scr_h;
    code_off = char_code - 8'(tcgr_pkg::FIRST_CODE);
    // codes outside the font draw as a space
    glyph_idx = (code_off < 8'(tcgr_pkg::GLYPH_COUNT)) ?
                code_off[tcgr_pkg::IDX_W-1:0] : '0;

    start.valid  = accept;
    start.base_x = cx_w;
    start.base_y = cy_w;
    start.fg     = fg_color;
    start.bg     = bg_color;
    if (!display_ready) begin
      start.kind = tcgr_pkg::ST_NOT_READY;
    end else if (off) begin
      start.kind = tcgr_pkg::ST_OFF;
    end else begin
      start.kind = tcgr_pkg::ST_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation   <= '0;
      display_ready <= 1'b0;
      cursor_x      <= '0;
      cursor_y      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcgr_pkg::REG_ORIENTATION:   orientation   <= cfg_data;
          tcgr_pkg::REG_DISPLAY_READY: display_ready <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && display_ready) begin
        // a wrap stays even when the cell then falls off screen
        cursor_x <= off ? cx_w : cx_w + CW'(tcgr_pkg::CELL_W);
        cursor_y <= cy_w;
      end
    end
  end

endmodule

@@ hw/rtl/tcgr_scan.sv @@
// ----------------------------------------------------------------------------
// tcgr_scan
// Walks the glyph cell, holds one pending pixel to mark the last one, and
// drives the output register.
// ----------------------------------------------------------------------------
module tcgr_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  tcgr_pkg::start_t              start,
  input  logic [tcgr_pkg::GLYPH_W-1:0]  glyph,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcgr_pkg::COORD_W-1:0]  out_x,
  output logic [tcgr_pkg::COORD_W-1:0]  out_y,
  output logic [tcgr_pkg::COLOR_W-1:0]  out_color,
  output tcgr_pkg::status_t             out_status,
  output logic                          out_last
);

  localparam int CW = tcgr_pkg::COORD_W;
  localparam logic [2:0] LAST_COL = 3'(tcgr_pkg::CELL_W - 1);
  localparam logic [2:0] LAST_ROW = 3'(tcgr_pkg::CELL_H - 1);

  tcgr_pkg::scan_state_t state, state_next;

  logic [2:0]                   col;
  logic [2:0]                   row;
  logic [CW-1:0]                base_x;
  logic [CW-1:0]                base_y;
  logic [tcgr_pkg::COLOR_W-1:0] fg;
  logic [tcgr_pkg::COLOR_W-1:0] bg;
  tcgr_pkg::status_t            flush_status;

  logic                         pend_valid;
  logic [CW-1:0]                pend_x;
  logic [CW-1:0]                pend_y;
  logic [tcgr_pkg::COLOR_W-1:0] pend_color;

  logic out_free;
  logic bit_set;
  logic emit;
  logic scan_step;
  logic scan_end;
  logic flush_go;

  always_comb begin
    out_free = !out_valid || out_ready;
    bit_set  = glyph[{col, row}];
    emit     = bit_set || (fg != bg);
    scan_step = 1'b0;
    flush_go  = 1'b0;
    in_ready  = 1'b0;
    unique case (state)
      tcgr_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      tcgr_pkg::S_SCAN: begin
        scan_step = !(emit && pend_valid && !out_free);
      end
      tcgr_pkg::S_FLUSH: begin
        flush_go = out_free;
        in_ready = out_free;
      end
      default: ;
    endcase
    scan_end = scan_step && (col == LAST_COL) && (row == LAST_ROW);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcgr_pkg::S_IDLE: begin
        if (start.valid) begin
          state_next = (start.kind == tcgr_pkg::ST_PIXEL) ?
                       tcgr_pkg::S_SCAN : tcgr_pkg::S_FLUSH;
        end
      end
      tcgr_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = tcgr_pkg::S_FLUSH;
        end
      end
      tcgr_pkg::S_FLUSH: begin
        if (flush_go) begin
          if (start.valid) begin
            state_next = (start.kind == tcgr_pkg::ST_PIXEL) ?
                         tcgr_pkg::S_SCAN : tcgr_pkg::S_FLUSH;
          end else begin
            state_next = tcgr_pkg::S_IDLE;
          end
        end
      end
      default: state_next = tcgr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcgr_pkg::S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (start.valid) begin
        col          <= '0;
        row          <= '0;
        base_x       <= start.base_x;
        base_y       <= start.base_y;
        fg           <= start.fg;
        bg           <= start.bg;
        flush_status <= (start.kind == tcgr_pkg::ST_PIXEL) ?
                        tcgr_pkg::ST_NOTHING : start.kind;
      end else if (scan_step) begin
        row <= (row == LAST_ROW) ? '0 : row + 3'd1;
        if (row == LAST_ROW) begin
          col <= col + 3'd1;
        end
      end

      if (scan_step && emit) begin
        pend_valid <= 1'b1;
        pend_x     <= base_x + CW'(col);
        pend_y     <= base_y + CW'(row);
        pend_color <= bit_set ? fg : bg;
      end else if (flush_go) begin
        pend_valid <= 1'b0;
      end

      if (scan_step && emit && pend_valid) begin
        out_valid  <= 1'b1;
        out_x      <= pend_x;
        out_y      <= pend_y;
        out_color  <= pend_color;
        out_status <= tcgr_pkg::ST_PIXEL;
        out_last   <= 1'b0;
      end else if (flush_go) begin
        out_valid  <= 1'b1;
        out_last   <= 1'b1;
        if (pend_valid) begin
          out_x      <= pend_x;
          out_y      <= pend_y;
          out_color  <= pend_color;
          out_status <= tcgr_pkg::ST_PIXEL;
        end else begin
          out_x      <= '0;
          out_y      <= '0;
          out_color  <= '0;
          out_status <= flush_status;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/text_cursor_glyph_renderer_core.sv @@
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer_core
// 6x8 bitmap font character generator with a wrapping text cursor.
// ----------------------------------------------------------------------------
// timing: a not-ready or off-screen result goes via the flush state to the
//   output register; a pixel waits in the pending register for the next drawn
//   cell bit or the flush; with equal colors skipped cell bits still take a
//   scan step each. A drawn character takes 48 cell scan steps, one per cycle
//   unless a stalled output holds them, then the flush state hands over the
//   final result; a not-ready or off-screen request takes only the flush state
// reset: synchronous, clears cursor, registers, scanner and output valid
// ----------------------------------------------------------------------------
module text_cursor_glyph_renderer_core #(
  parameter int PANEL_WIDTH  = tcgr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tcgr_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [1:0]                    cfg_data,
  // character requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  input  logic [tcgr_pkg::COLOR_W-1:0]  fg_color,
  input  logic [tcgr_pkg::COLOR_W-1:0]  bg_color,
  // pixel results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcgr_pkg::COORD_W-1:0]  pixel_x,
  output logic [tcgr_pkg::COORD_W-1:0]  pixel_y,
  output logic [tcgr_pkg::COLOR_W-1:0]  pixel_color,
  output logic [1:0]                    status,
  output logic                          last
);

  logic                          accept;
  logic [tcgr_pkg::IDX_W-1:0]    glyph_idx;
  logic [tcgr_pkg::GLYPH_W-1:0]  glyph;
  tcgr_pkg::start_t              start;
  tcgr_pkg::status_t             out_status;

  // a request is taken while idle or in the cycle the previous one finishes
  assign accept = in_valid && in_ready;
  assign status = out_status;

  // cursor, wrap and off-screen decision happen at accept time
  tcgr_cursor #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .char_code (char_code),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .glyph_idx (glyph_idx),
    .start     (start)
  );

  // font memory is read once per request, data ready for the first scan step
  tcgr_glyph_rom u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (glyph_idx),
    .rd_data (glyph)
  );

  // column-major walk of the cell, one pixel decision per cycle unless a stalled output holds the scan
  tcgr_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .glyph      (glyph),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (pixel_x),
    .out_y      (pixel_y),
    .out_color  (pixel_color),
    .out_status (out_status),
    .out_last   (last)
  );

endmodule

@@ hw/rtl/tcgr_checker.sv @@
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks of the glyph renderer result stream.
// ----------------------------------------------------------------------------
module tcgr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcgr_pkg::COORD_W-1:0]  pixel_x,
  input logic [tcgr_pkg::COORD_W-1:0]  pixel_y,
  input logic [tcgr_pkg::COLOR_W-1:0]  pixel_color,
  input logic [1:0]                    status,
  input logic                          last
);

  // inside a character after a non-final pixel was taken
  logic mid_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_char <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_char <= (status == tcgr_pkg::ST_PIXEL) && !last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_special: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != tcgr_pkg::ST_PIXEL) |->
      last && (pixel_x == '0) && (pixel_y == '0) && (pixel_color == '0))
    else $error("status result not final or not zeroed");

  a_char_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid_char |-> (status == tcgr_pkg::ST_PIXEL))
    else $error("status result inside an open character");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_cursor_glyph_renderer_core tcgr_checker u_tcgr_checker (.*);
